FILE: sv/tlb_fully_associative_replace_assert.svh
// Assertion macros for the translation buffer
`ifndef TLB_FULLY_ASSOCIATIVE_REPLACE_ASSERT_SVH
`define TLB_FULLY_ASSOCIATIVE_REPLACE_ASSERT_SVH

`define TLB_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TLB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/tlbfa_pkg.sv
`default_nettype none
package tlbfa_pkg;
  localparam int TLB_DEPTH = 16;
  localparam int PAGE_BITS = 20;
  localparam int FRAME_BITS = 20;
  localparam int TIME_BITS = 32;
  localparam int IDX_BITS = $clog2(TLB_DEPTH);
  localparam int CNT_BITS = 5;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_INVAL  = 2'd2;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_ENTRIES = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_POLICY  = 1'd1;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } tlbfa_cmd_t;

  typedef struct packed {
    logic scan_last;
  } tlbfa_sts_t;
endpackage
`default_nettype wire

FILE: sv/tlbfa_if.sv
`default_nettype none
interface tlbfa_in_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [19:0] page_number;
  logic [19:0] frame_in;
  logic [31:0] now;
  modport source (output valid, opcode, page_number, frame_in, now, input ready);
  modport sink (input valid, opcode, page_number, frame_in, now, output ready);
endinterface

interface tlbfa_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [19:0] frame_out;
  modport source (output valid, hit, frame_out, input ready);
  modport sink (input valid, hit, frame_out, output ready);
endinterface
`default_nettype wire

FILE: sv/tlbfa_ctrl.sv
`default_nettype none
module tlbfa_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output tlbfa_pkg::tlbfa_cmd_t cmd,
  input  wire tlbfa_pkg::tlbfa_sts_t sts
);
  import tlbfa_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic ovalid_r, ovalid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          cmd.commit = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: sv/tlbfa_dp.sv
`default_nettype none
module tlbfa_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tlbfa_pkg::tlbfa_cmd_t cmd,
  output tlbfa_pkg::tlbfa_sts_t sts,
  input  wire logic [1:0] in_opcode,
  input  wire logic [tlbfa_pkg::PAGE_BITS-1:0] in_page,
  input  wire logic [tlbfa_pkg::FRAME_BITS-1:0] in_frame,
  input  wire logic [tlbfa_pkg::TIME_BITS-1:0] in_now,
  input  wire logic [tlbfa_pkg::CNT_BITS-1:0] entries_in_use,
  input  wire logic replace_policy,
  output logic hit,
  output logic [tlbfa_pkg::FRAME_BITS-1:0] frame_out
);
  import tlbfa_pkg::*;
  localparam int QBITS = 2;
  localparam int QLEN = TLB_DEPTH / 4;

  logic [TLB_DEPTH-1:0] valid_r;
  logic [PAGE_BITS-1:0] page_r [TLB_DEPTH];
  logic [FRAME_BITS-1:0] frame_r [TLB_DEPTH];
  logic [TIME_BITS-1:0] use_r [TLB_DEPTH];
  logic [TIME_BITS-1:0] load_r [TLB_DEPTH];

  logic [1:0] op_r;
  logic [PAGE_BITS-1:0] pg_r;
  logic [FRAME_BITS-1:0] fr_r;
  logic [TIME_BITS-1:0] now_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [QBITS-1:0] qtr_r;

  logic mfound_r, ifound_r;
  logic [IDX_BITS-1:0] midx_r, iidx_r, vidx_r;
  logic [TIME_BITS-1:0] vtime_r;
  logic hit_r;
  logic [FRAME_BITS-1:0] fout_r;

  logic [TLB_DEPTH-1:0] act;
  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) act[i] = (CNT_BITS'(i) < cnt_r);
  end

  // Scan a quarter of the slots per cycle, keeping the running first match,
  // first free slot and oldest time.
  logic mf, ff;
  logic [IDX_BITS-1:0] mi, fi, vi;
  logic [TIME_BITS-1:0] vt;
  always_comb begin
    logic [IDX_BITS-1:0] k;
    logic [TIME_BITS-1:0] t;
    mf = mfound_r; mi = midx_r;
    ff = ifound_r; fi = iidx_r;
    vi = vidx_r; vt = vtime_r;
    for (int j = 0; j < QLEN; j++) begin
      k = IDX_BITS'(qtr_r) * IDX_BITS'(QLEN) + IDX_BITS'(j);
      t = replace_policy ? use_r[k] : load_r[k];
      if (act[k]) begin
        if (!mf && valid_r[k] && page_r[k] == pg_r) begin
          mf = 1'b1; mi = k;
        end
        if (!ff && !valid_r[k]) begin
          ff = 1'b1; fi = k;
        end
        if (k == '0 || t < vt) begin
          vt = t; vi = k;
        end
      end
    end
  end

  assign sts.scan_last = (qtr_r == QBITS'(QLEN == 0 ? 0 : 3));

  logic do_ok;
  assign do_ok = (cnt_r != '0) && (op_r <= OP_INVAL);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      pg_r <= in_page;
      fr_r <= in_frame;
      now_r <= in_now;
      cnt_r <= (entries_in_use > CNT_BITS'(TLB_DEPTH)) ? CNT_BITS'(TLB_DEPTH)
                                                        : entries_in_use;
      qtr_r <= '0;
      mfound_r <= 1'b0;
      ifound_r <= 1'b0;
      midx_r <= '0; iidx_r <= '0; vidx_r <= '0; vtime_r <= '0;
    end else if (cmd.scan_step) begin
      qtr_r <= qtr_r + 1'b1;
      mfound_r <= mf; midx_r <= mi;
      ifound_r <= ff; iidx_r <= fi;
      vidx_r <= vi; vtime_r <= vt;
    end
    if (cmd.commit) begin
      hit_r <= 1'b0;
      fout_r <= '0;
      if (do_ok) begin
        unique case (op_r)
          OP_LOOKUP: if (mfound_r) begin
            use_r[midx_r] <= now_r;
            hit_r <= 1'b1;
            fout_r <= frame_r[midx_r];
          end
          OP_INSERT: begin
            if (mfound_r) begin
              frame_r[midx_r] <= fr_r;
              use_r[midx_r] <= now_r;
              hit_r <= 1'b1;
            end else begin
              page_r[ifound_r ? iidx_r : vidx_r] <= pg_r;
              frame_r[ifound_r ? iidx_r : vidx_r] <= fr_r;
              use_r[ifound_r ? iidx_r : vidx_r] <= now_r;
              load_r[ifound_r ? iidx_r : vidx_r] <= now_r;
            end
          end
          OP_INVAL: if (mfound_r) hit_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && do_ok) begin
      if (op_r == OP_INSERT && !mfound_r)
        valid_r[ifound_r ? iidx_r : vidx_r] <= 1'b1;
      else if (op_r == OP_INVAL && mfound_r)
        valid_r[midx_r] <= 1'b0;
    end
  end

  assign hit = hit_r;
  assign frame_out = fout_r;
endmodule
`default_nettype wire

FILE: sv/tlb_fully_associative_replace.sv
// Each accepted request is scanned in 4 steps, then committed to the output.
// The scan covers 16 slots, 4 slots per cycle, in the shared match/victim unit;
//   a new request is accepted only once the previous one has committed.
// A finished result may wait in the output register while the next scan runs.
// Reset (synchronous, rst_n low) clears all valid bits, the controller and
//   the configuration registers (entries_in_use 16, replace_policy FIFO).
`default_nettype none
`include "tlb_fully_associative_replace_assert.svh"
module tlb_fully_associative_replace (
  input  wire logic clk,
  input  wire logic rst_n,
  tlbfa_in_if.sink in_ch,
  tlbfa_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [tlbfa_pkg::CFG_ADDR_BITS-1:0] cfg_index,
  input  wire logic [tlbfa_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tlbfa_pkg::*;

  logic [CNT_BITS-1:0] entries_r;
  logic policy_r;
  tlbfa_cmd_t cmd;
  tlbfa_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CNT_BITS'(TLB_DEPTH);
      policy_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRIES: entries_r <= cfg_data;
        CFG_POLICY: policy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlbfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  tlbfa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_ch.opcode), .in_page(in_ch.page_number),
    .in_frame(in_ch.frame_in), .in_now(in_ch.now),
    .entries_in_use(entries_r), .replace_policy(policy_r),
    .hit(out_ch.hit), .frame_out(out_ch.frame_out)
  );

  `TLB_ASSERT_IMPL(a_accept_to_scan, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "request accepted but controller stayed idle")
  `TLB_ASSERT_NEVER(a_commit_no_load, clk, rst_n, cmd.commit && cmd.load, "commit and load together")
  `TLB_ASSERT_IMPL(a_commit_valid, clk, rst_n, cmd.commit |=> out_ch.valid, "commit without result")
endmodule
`default_nettype wire

FILE: test/tb_top.sv
module tb_top;
  import tlbfa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  tlbfa_in_if in_ch();
  tlbfa_out_if out_ch();

  tlb_fully_associative_replace dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic hit;
    logic [FRAME_BITS-1:0] frame;
  } tlb_resp_t;

  class tlb_scoreboard;
    bit vld[TLB_DEPTH];
    logic [PAGE_BITS-1:0] pg[TLB_DEPTH];
    logic [FRAME_BITS-1:0] frm[TLB_DEPTH];
    logic [TIME_BITS-1:0] used[TLB_DEPTH];
    logic [TIME_BITS-1:0] loaded[TLB_DEPTH];
    int unsigned n_entries = 16;
    bit use_lru = 0;
    tlb_resp_t pending[$];
    int errors = 0;
    int hits = 0;
    int checked = 0;

    function void note_request(logic [1:0] op, logic [PAGE_BITS-1:0] page,
                               logic [FRAME_BITS-1:0] frame, logic [TIME_BITS-1:0] now);
      int cnt;
      int m;
      int slot;
      tlb_resp_t r;
      cnt = (n_entries > TLB_DEPTH) ? TLB_DEPTH : n_entries;
      r = '0;
      m = -1;
      for (int i = cnt - 1; i >= 0; i--) if (vld[i] && pg[i] == page) m = i;
      if (cnt != 0) begin
        if (op == OP_LOOKUP) begin
          if (m >= 0) begin
            used[m] = now;
            r.hit = 1;
            r.frame = frm[m];
          end
        end else if (op == OP_INSERT) begin
          if (m >= 0) begin
            frm[m] = frame;
            used[m] = now;
            r.hit = 1;
          end else begin
            slot = -1;
            for (int i = cnt - 1; i >= 0; i--) if (!vld[i]) slot = i;
            if (slot < 0) begin
              slot = 0;
              for (int i = 1; i < cnt; i++)
                if ((use_lru ? used[i] : loaded[i]) < (use_lru ? used[slot] : loaded[slot]))
                  slot = i;
            end
            vld[slot] = 1;
            pg[slot] = page;
            frm[slot] = frame;
            loaded[slot] = now;
            used[slot] = now;
          end
        end else if (op == OP_INVAL) begin
          if (m >= 0) begin
            vld[m] = 0;
            r.hit = 1;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function bit check_response(tlb_resp_t got, output tlb_resp_t want);
      checked++;
      if (got.hit) hits++;
      if (pending.size() == 0) begin
        want = 'x;
        return 0;
      end
      want = pending.pop_front();
      return got === want;
    endfunction
  endclass

  tlb_scoreboard sb = new();
  int fails = 0;
  bit no_idle = 0;
  bit hold_off = 0;

  task automatic report(string what);
    $display("mismatch: %s", what);
    fails++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENTRIES) sb.n_entries = val;
    else sb.use_lru = val[0];
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send(logic [1:0] op, logic [19:0] page, logic [19:0] frame,
                      logic [31:0] now);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.page_number <= page;
    in_ch.frame_in <= frame;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, page, frame, now);
  endtask

  always @(posedge clk) begin
    tlb_resp_t got;
    tlb_resp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit = out_ch.hit;
      got.frame = out_ch.frame_out;
      if (!sb.check_response(got, want))
        report($sformatf("got hit=%0b frame=%h want hit=%0b frame=%h",
                         got.hit, got.frame, want.hit, want.frame));
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #50000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] t;
    logic [1:0] op;
    logic [19:0] page;
    int sizes[6] = '{16, 0, 1, 31, 5, 16};
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_LOOKUP;
    in_ch.page_number <= '0;
    in_ch.frame_in <= '0;
    in_ch.now <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    t = 0;
    // directed: extremes, all opcodes, unused opcode, update, invalidate
    send(OP_LOOKUP, 20'h0, 20'h0, 32'h0);
    send(OP_INSERT, 20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF);
    send(OP_LOOKUP, 20'hFFFFF, 20'h0, 32'h0);
    send(OP_INSERT, 20'hFFFFF, 20'h12345, 32'h5);
    send(OP_LOOKUP, 20'hFFFFF, 20'h0, 32'h6);
    send(OP_INSERT, 20'h0, 20'h0, 32'h0);
    send(2'd3, 20'hFFFFF, 20'hFFFFF, 32'h7);
    send(OP_INVAL, 20'hFFFFF, 20'h0, 32'h8);
    send(OP_INVAL, 20'hFFFFF, 20'h0, 32'h9);
    send(OP_LOOKUP, 20'hFFFFF, 20'h0, 32'h9);
    for (int i = 0; i < 12; i++) send(OP_INSERT, 20'(i + 100), 20'(i), 32'(20 - i));
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_ENTRIES, 5'(ph < 6 ? sizes[ph] : $urandom_range(0, 31)));
      write_reg(CFG_POLICY, 5'(ph % 2));
      if (ph == 3) hold_off = 1;
      if (ph == 10) no_idle = 1;
      for (int k = 0; k < 160; k++) begin
        t = t + $urandom_range(0, 3);
        op = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(0, 2));
        page = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                           : 20'($urandom_range(0, 23) ^ (k & 20'hF0000));
        if ($urandom_range(0, 30) == 0) t = $urandom;
        send(op, page, 20'($urandom), t);
      end
      drain();
    end
    $display("covered %0d results (%0d hits) over 12 count/policy phases",
             sb.checked, sb.hits);
    if (fails == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
